FILE: sv/score_table_accumulate_prune_defines.svh
// Assertion macros shared by the score table RTL.
// Each macro expects clk and arst_n in scope of the module that uses it.
`ifndef SCORE_TABLE_ACCUMULATE_PRUNE_DEFINES_SVH
`define SCORE_TABLE_ACCUMULATE_PRUNE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define STAP_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("score table check failed");

// Same-cycle implication.
`define STAP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("score table check failed");

// Next-cycle implication.
`define STAP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("score table check failed");

`endif

FILE: sv/stap_pkg.sv
// Types and constants of the score table block.
// No dependencies; imported by stap_merge, the top level and the testbench.
`default_nettype none

package stap_pkg;

	localparam int unsigned TABLE_DEPTH = 256;
	localparam logic [7:0]  SCORE_MAX   = 8'd255;
	localparam logic [4:0]  MAX_RESULTS = 5'd16;

	typedef enum logic [1:0] {
		CMD_ACC   = 2'd0,
		CMD_DRAIN = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] code;
		logic [7:0] prob;
	} stap_in_t;

	typedef struct packed {
		logic [7:0] out_code;
		logic [7:0] out_prob;
		logic       last;
		logic       empty_res;
	} stap_out_t;

endpackage

`default_nettype wire

FILE: sv/stap_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stap_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Hold the last read word while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/stap_merge.sv
// Score merge unit: new = old + prob - floor(old*prob/255), clamped to 255.
// Depends on stap_pkg for the score ceiling.
`default_nettype none

module stap_merge (
	input  wire logic [7:0] old_score,
	input  wire logic [7:0] prob,
	output logic      [7:0] new_score
);
	import stap_pkg::*;

	logic [15:0] prod;
	logic [16:0] fold;
	logic [7:0]  quot;
	logic [9:0]  sum;

	always_comb begin
		prod = 16'(old_score) * 16'(prob);
		// Divide by 255 through the reciprocal: (x + (x >> 8) + 1) >> 8.
		fold = 17'(prod) + 17'(prod[15:8]) + 17'd1;
		quot = fold[15:8];
		sum  = 10'(old_score) + 10'(prob) - 10'(quot);
		if (sum > 10'(SCORE_MAX)) begin
			new_score = SCORE_MAX;
		end else begin
			new_score = sum[7:0];
		end
	end

endmodule

`default_nettype wire

FILE: sv/score_table_accumulate_prune.sv
// Score table top level: table RAM, accumulate path, prune/drain sequencer.
// Depends on stap_pkg, stap_ram, stap_merge and the assertion macro header.
//
//   channel   dir  handshake                 payload
//   item      in   item_valid / item_ready   stap_in_t  (cmd, code, prob)
//   res       out  res_valid / res_ready     stap_out_t (out_code, out_prob, last, empty_res)
//   cfg       in   cfg_we                    cfg_wdata (max_out)
//
// Accumulates and clears are taken while idle; accumulates stream back to back
// through the RAM read port and a one-entry write forward.
// A drain runs a scan pass over the RAM read port, one more pass per prune round,
// then a listing that reads and checks each entry visited.
// Reset clears the table at once through per-entry valid flops; no clearing pass.
// A stalled result holds the listing in place; item_ready is low during a drain.
`default_nettype none
`include "score_table_accumulate_prune_defines.svh"

module score_table_accumulate_prune #(
	parameter int unsigned MAX_VERSIONS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire stap_pkg::stap_in_t item,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output stap_pkg::stap_out_t     res,
	input  wire logic               cfg_we,
	input  wire logic [4:0]         cfg_wdata
);
	import stap_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_SCAN     = 7'b0000010,
		ST_TAIL     = 7'b0000100,
		ST_DECIDE   = 7'b0001000,
		ST_LIST_RD  = 7'b0010000,
		ST_LIST_CHK = 7'b0100000,
		ST_EMPTY    = 7'b1000000
	} state_t;

	state_t state_q;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [4:0]  max_out_q;
	logic [4:0]  cap;

	// accumulate pipeline
	logic        acc_accept;
	logic        acc_v_s1;
	logic [7:0]  code_s1;
	logic [7:0]  prob_s1;
	logic        fwd_v_q;
	logic [7:0]  fwd_addr_q;
	logic [7:0]  fwd_data_q;
	logic [7:0]  acc_old;
	logic [7:0]  acc_new;

	// scan and listing
	logic [7:0]  idx_q;
	logic        scan_v_s1;
	logic [7:0]  scan_idx_s1;
	logic [7:0]  scan_d;
	logic [8:0]  count_q;
	logic [7:0]  low_q;
	logic [7:0]  kill_q;
	logic [4:0]  n_q;
	logic [4:0]  emit_q;
	logic [7:0]  list_d;
	logic        list_last;
	logic        res_free;
	logic        load_list;
	logic        load_empty;

	// RAM ports
	logic        ram_re;
	logic [7:0]  ram_raddr;
	logic [7:0]  ram_rdata;

	logic        res_valid_q;
	stap_out_t   res_q;

	assign item_ready = (state_q == ST_IDLE);
	assign acc_accept = item_valid && item_ready && (item.cmd == CMD_ACC);
	assign res_valid  = res_valid_q;
	assign res        = res_q;
	assign res_free   = !res_valid_q || res_ready;

	assign ram_re    = acc_accept || (state_q == ST_SCAN) || (state_q == ST_LIST_RD);
	assign ram_raddr = (state_q == ST_IDLE) ? item.code : idx_q;

	stap_ram #(
		.WIDTH(8),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (acc_v_s1),
		.waddr(code_s1),
		.wdata(acc_new),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	stap_merge u_merge (
		.old_score(acc_old),
		.prob     (prob_s1),
		.new_score(acc_new)
	);

	always_comb begin
		// Forward the write of the previous beat; the RAM returns old data then.
		if (fwd_v_q && (fwd_addr_q == code_s1)) begin
			acc_old = fwd_data_q;
		end else if (valid_q[code_s1]) begin
			acc_old = ram_rdata;
		end else begin
			acc_old = 8'd0;
		end

		scan_d = valid_q[scan_idx_s1] ? ram_rdata : 8'd0;
		list_d = valid_q[idx_q] ? ram_rdata : 8'd0;

		if (max_out_q == 5'd0) begin
			cap = 5'd1;
		end else if (max_out_q > MAX_RESULTS) begin
			cap = MAX_RESULTS;
		end else begin
			cap = max_out_q;
		end

		list_last  = (emit_q == (n_q - 5'd1));
		load_list  = (state_q == ST_LIST_CHK) && (list_d != 8'd0) && res_free;
		load_empty = (state_q == ST_EMPTY) && res_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			max_out_q   <= MAX_RESULTS;
			acc_v_s1    <= 1'b0;
			fwd_v_q     <= 1'b0;
			scan_v_s1   <= 1'b0;
			scan_idx_s1 <= 8'd0;
			idx_q       <= 8'd0;
			count_q     <= 9'd0;
			low_q       <= SCORE_MAX;
			kill_q      <= 8'd0;
			n_q         <= 5'd0;
			emit_q      <= 5'd0;
			res_valid_q <= 1'b0;
		end else begin
			acc_v_s1  <= acc_accept;
			fwd_v_q   <= acc_v_s1;
			scan_v_s1 <= 1'b0;

			if (cfg_we) begin
				max_out_q <= cfg_wdata;
			end
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (acc_v_s1) begin
				valid_q[code_s1] <= 1'b1;
			end

			// Drop entries at the killed score, count and track the rest.
			if (scan_v_s1 && (scan_d != 8'd0)) begin
				if (scan_d == kill_q) begin
					valid_q[scan_idx_s1] <= 1'b0;
				end else begin
					count_q <= count_q + 9'd1;
					if (scan_d < low_q) begin
						low_q <= scan_d;
					end
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						case (item.cmd)
							CMD_DRAIN: begin
								idx_q   <= 8'd0;
								count_q <= 9'd0;
								low_q   <= SCORE_MAX;
								kill_q  <= 8'd0;
								state_q <= ST_SCAN;
							end
							CMD_CLEAR: begin
								valid_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					scan_v_s1   <= 1'b1;
					scan_idx_s1 <= idx_q;
					idx_q       <= idx_q + 8'd1;
					if (idx_q == 8'hFF) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (count_q > 9'(MAX_VERSIONS)) begin
						kill_q  <= low_q;
						count_q <= 9'd0;
						low_q   <= SCORE_MAX;
						idx_q   <= 8'd0;
						state_q <= ST_SCAN;
					end else if (count_q == 9'd0) begin
						state_q <= ST_EMPTY;
					end else begin
						n_q     <= (count_q < 9'(cap)) ? count_q[4:0] : cap;
						emit_q  <= 5'd0;
						idx_q   <= 8'd0;
						state_q <= ST_LIST_RD;
					end
				end
				ST_LIST_RD: begin
					state_q <= ST_LIST_CHK;
				end
				ST_LIST_CHK: begin
					if (list_d == 8'd0) begin
						idx_q   <= idx_q + 8'd1;
						state_q <= (idx_q == 8'hFF) ? ST_IDLE : ST_LIST_RD;
					end else if (res_free) begin
						res_valid_q <= 1'b1;
						emit_q      <= emit_q + 5'd1;
						if (list_last || (idx_q == 8'hFF)) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 8'd1;
							state_q <= ST_LIST_RD;
						end
					end
				end
				ST_EMPTY: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc_accept) begin
			code_s1 <= item.code;
			prob_s1 <= item.prob;
		end
		if (acc_v_s1) begin
			fwd_addr_q <= code_s1;
			fwd_data_q <= acc_new;
		end
		if (load_list) begin
			res_q.out_code  <= idx_q;
			res_q.out_prob  <= list_d;
			res_q.last      <= list_last;
			res_q.empty_res <= 1'b0;
		end else if (load_empty) begin
			res_q.out_code  <= 8'd0;
			res_q.out_prob  <= 8'd0;
			res_q.last      <= 1'b0;
			res_q.empty_res <= 1'b1;
		end
	end

	`STAP_ASSERT_IMP(a_acc_only_idle, acc_v_s1, state_q == ST_IDLE)
	`STAP_ASSERT_IMP(a_emit_bound, state_q == ST_LIST_CHK, emit_q < n_q)
	`STAP_ASSERT_NXT(a_prune_rescan, (state_q == ST_DECIDE) && (count_q > 9'(MAX_VERSIONS)),
		(state_q == ST_SCAN) && (idx_q == 8'd0))
	`STAP_ASSERT_NXT(a_scan_wrap, (state_q == ST_SCAN) && (idx_q == 8'hFF), state_q == ST_TAIL)
	`STAP_ASSERT_IMP(a_empty_clean, res_valid_q && res_q.empty_res,
		!res_q.last && (res_q.out_code == 8'd0) && (res_q.out_prob == 8'd0))

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking bench for score_table_accumulate_prune: accumulate, prune, drain, clear.
// Predicts the drain listings from a local copy of the score table and checks every beat.
// Depends on stap_pkg and the score_table_accumulate_prune top level.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import stap_pkg::*;

	localparam int unsigned VERSION_LIMIT  = 16;
	localparam int unsigned HOLDOFF_CYCLES = 4000;
	localparam int unsigned SETTLE_CYCLES  = 20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	stap_in_t   item = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	stap_out_t  res;
	logic       cfg_we = 1'b0;
	logic [4:0] cfg_wdata = 5'd0;

	score_table_accumulate_prune #(
		.MAX_VERSIONS(VERSION_LIMIT)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Local copy of the table and of max_out
	logic [7:0]  score_shadow [TABLE_DEPTH];
	logic [4:0]  listing_cap = 5'd16;

	stap_in_t    pending_items[$];
	stap_out_t   expected_listing[$];
	int unsigned items_queued = 0;
	int unsigned items_accepted = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned holdoffs_asked = 0;
	int unsigned holdoffs_served = 0;
	int unsigned holdoff_left = 0;
	int unsigned fail_count = 0;
	logic [7:0]  code_base = 8'd0;
	stap_out_t   beat_want;

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			score_shadow[i] = 8'd0;
		end
	end

	function automatic void predict_item(stap_in_t it);
		int unsigned old_score, merged, live, low, cap, listed;
		stap_out_t beat;
		case (cmd_t'(it.cmd))
			CMD_ACC: begin
				old_score = score_shadow[it.code];
				merged = old_score + it.prob - (old_score * it.prob) / SCORE_MAX;
				if (merged > SCORE_MAX)
					merged = SCORE_MAX;
				score_shadow[it.code] = 8'(merged);
			end
			CMD_CLEAR: begin
				for (int i = 0; i < TABLE_DEPTH; i++)
					score_shadow[i] = 8'd0;
			end
			CMD_DRAIN: begin
				// drop the weakest score until few enough entries survive
				do begin
					live = 0;
					low = SCORE_MAX;
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						if (score_shadow[i] != 8'd0) begin
							live++;
							if (score_shadow[i] < low)
								low = score_shadow[i];
						end
					end
					if (live > VERSION_LIMIT) begin
						for (int i = 0; i < TABLE_DEPTH; i++)
							if (score_shadow[i] == low)
								score_shadow[i] = 8'd0;
					end
				end while (live > VERSION_LIMIT);
				cap = listing_cap;
				if (cap == 0)
					cap = 1;
				if (cap > MAX_RESULTS)
					cap = MAX_RESULTS;
				listed = 0;
				for (int i = 0; i < TABLE_DEPTH && listed < cap; i++) begin
					if (score_shadow[i] != 8'd0) begin
						beat.out_code  = 8'(i);
						beat.out_prob  = score_shadow[i];
						beat.last      = 1'b0;
						beat.empty_res = 1'b0;
						expected_listing.push_back(beat);
						listed++;
					end
				end
				if (listed == 0) begin
					beat = '0;
					beat.empty_res = 1'b1;
					expected_listing.push_back(beat);
				end else begin
					beat = expected_listing.pop_back();
					beat.last = 1'b1;
					expected_listing.push_back(beat);
				end
			end
			default: ;
		endcase
	endfunction

	// Item driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && item_ready) begin
				predict_item(item);
				items_accepted++;
			end
			if (!item_valid || item_ready) begin
				if (pending_items.size() != 0 &&
				    !(send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)) begin
					item_valid <= 1'b1;
					item <= pending_items.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted in cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left <= 0;
		end else if (holdoffs_asked != holdoffs_served) begin
			holdoff_left <= HOLDOFF_CYCLES;
			holdoffs_served <= holdoffs_served + 1;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_listing.size() == 0) begin
					$error("unexpected result beat: out_code %0d out_prob %0d last %0b empty_res %0b",
						res.out_code, res.out_prob, res.last, res.empty_res);
					fail_count++;
				end else begin
					beat_want = expected_listing.pop_front();
					if (res.out_code !== beat_want.out_code) begin
						$error("out_code: expected %0d, got %0d", beat_want.out_code, res.out_code);
						fail_count++;
					end
					if (res.out_prob !== beat_want.out_prob) begin
						$error("out_prob: expected %0d, got %0d", beat_want.out_prob, res.out_prob);
						fail_count++;
					end
					if (res.last !== beat_want.last) begin
						$error("last: expected %0b, got %0b", beat_want.last, res.last);
						fail_count++;
					end
					if (res.empty_res !== beat_want.empty_res) begin
						$error("empty_res: expected %0b, got %0b", beat_want.empty_res,
							res.empty_res);
						fail_count++;
					end
				end
			end
			if (holdoff_left != 0) begin
				res_ready <= 1'b0;
			end else begin
				res_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic send(cmd_t cmd, logic [7:0] code, logic [7:0] prob);
		stap_in_t it;
		it.cmd  = cmd;
		it.code = code;
		it.prob = prob;
		pending_items.push_back(it);
		items_queued++;
	endtask

	function automatic stap_in_t random_item();
		stap_in_t it;
		int unsigned roll;
		roll = $urandom_range(99);
		it.code = 8'($urandom_range(255));
		it.prob = 8'($urandom_range(255));
		if (roll < 70) begin
			it.cmd = CMD_ACC;
			// keep most codes in a narrow window so entries merge and prune rounds stay short
			if ($urandom_range(3) != 0)
				it.code = 8'(code_base + $urandom_range(23));
			case ($urandom_range(7))
				0: it.prob = 8'd0;
				1: it.prob = SCORE_MAX;
				default: ;
			endcase
		end else if (roll < 86) begin
			it.cmd = CMD_DRAIN;
		end else if (roll < 94) begin
			it.cmd = CMD_CLEAR;
		end else begin
			it.cmd = CMD_NONE;
		end
		return it;
	endfunction

	// Hold until every item is in and every listing beat is out
	task automatic settle();
		while (items_accepted != items_queued || expected_listing.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cap(logic [4:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		listing_cap = value;
	endtask

	task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, logic [4:0] cap,
		int unsigned count);
		settle();
		write_cap(cap);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		code_base = 8'($urandom_range(255));
		for (int unsigned k = 0; k < count; k++) begin
			pending_items.push_back(random_item());
			items_queued++;
		end
	endtask

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, merge extremes, saturation, ignored command
		send(CMD_DRAIN, 8'd0, 8'd0);
		send(CMD_ACC, 8'd0, SCORE_MAX);
		send(CMD_ACC, 8'd255, 8'd0);
		send(CMD_ACC, 8'd0, SCORE_MAX);
		send(CMD_ACC, 8'd128, 8'd1);
		send(CMD_ACC, 8'd128, 8'd1);
		send(CMD_ACC, 8'd7, 8'd200);
		send(CMD_ACC, 8'd7, 8'd100);
		send(CMD_NONE, 8'd9, 8'd99);
		send(CMD_DRAIN, 8'hff, 8'hff);
		send(CMD_CLEAR, 8'haa, 8'h55);
		// two prune rounds: a tied minimum pair, then a single next-lowest entry
		for (int unsigned c = 10; c < 29; c++) begin
			if (c < 12)
				send(CMD_ACC, 8'(c), 8'd3);
			else if (c == 12)
				send(CMD_ACC, 8'(c), 8'd4);
			else
				send(CMD_ACC, 8'(c), 8'(20 + (c - 13) * 10));
		end
		send(CMD_DRAIN, 8'd0, 8'd0);

		run_phase(0, 0, 5'd16, 12);
		run_phase(79, 0, 5'd1, 12);
		run_phase(0, 79, 5'd0, 12);
		run_phase(11, 11, 5'd31, 12);
		run_phase(0, 0, 5'($urandom_range(15, 2)), 12);

		// back-pressure: stall the result side long enough for the drain to block input
		settle();
		write_cap(5'd16);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send(CMD_CLEAR, 8'd0, 8'd0);
		for (int unsigned k = 0; k < 24; k++)
			send(CMD_ACC, 8'(60 + k * 3), 8'($urandom_range(255, 1)));
		holdoffs_asked++;
		send(CMD_DRAIN, 8'd0, 8'd0);
		for (int unsigned k = 0; k < 8; k++) begin
			pending_items.push_back(random_item());
			items_queued++;
		end
		send(CMD_DRAIN, 8'd0, 8'd0);

		settle();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && expected_listing.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin : watchdog
		#30ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/stap_pkg.sv
sv/stap_ram.sv
sv/stap_merge.sv
sv/score_table_accumulate_prune.sv
dv/testbench.sv
